// ===== design/gain_envelope_shaper_assert.svh =====
// Assertion macros of the gain envelope shaper back end
`ifndef GAIN_ENVELOPE_SHAPER_ASSERT_SVH
`define GAIN_ENVELOPE_SHAPER_ASSERT_SVH
`ifndef SYNTHESIS
`define GES_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define GES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define GES_ASSERT(lbl, prop)
`define GES_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== design/ges_pkg.sv =====
// Shared types and constants of the gain envelope shaper
`timescale 1ns / 1ps
package ges_pkg;
	localparam int POS_W  = 24;
	localparam int FRAC_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LAST_POINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX        = 2'd2;

	localparam logic MODE_POINT  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [15:0] MIX_FULL = 16'd32768;
	localparam logic [7:0]  LAST_RESET = 8'd255;

	typedef struct packed {
		logic               mode;
		logic [7:0]         point_index;
		logic [14:0]        point_gain;
		logic signed [15:0] sample_in;
		logic               first_sample;
	} item_t;
endpackage

// ===== design/ges_in_if.sv =====
// Input request channel of the gain envelope shaper
`timescale 1ns / 1ps
interface ges_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [7:0]         point_index;
	logic [14:0]        point_gain;
	logic signed [15:0] sample_in;
	logic               first_sample;

	modport source (output valid, mode, point_index, point_gain, sample_in, first_sample,
		input ready);
	modport sink (input valid, mode, point_index, point_gain, sample_in, first_sample,
		output ready);
endinterface

// ===== design/ges_out_if.sv =====
// Output request channel of the gain envelope shaper
`timescale 1ns / 1ps
interface ges_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               clipped;

	modport source (output valid, sample_out, clipped, input ready);
	modport sink (input valid, sample_out, clipped, output ready);
endinterface

// ===== design/ges_front.sv =====
// Front end: accepts requests into a two-entry queue
`timescale 1ns / 1ps
module ges_front
	import ges_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	ges_in_if.sink  in_ch,
	output logic    q_valid,
	output item_t   q_item,
	input  logic    q_pop
);
	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_ch.ready = (count_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (count_q != 2'd0);
	assign q_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{mode: in_ch.mode, point_index: in_ch.point_index,
				point_gain: in_ch.point_gain, sample_in: in_ch.sample_in,
				first_sample: in_ch.first_sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== design/ges_back.sv =====
// Back end: gain table, step divider, interpolation, mixing and output register
`timescale 1ns / 1ps
`include "gain_envelope_shaper_assert.svh"
module ges_back
	import ges_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int LENGTH_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  item_t                  q_item,
	output logic                   q_pop,
	input  logic [7:0]             cfg_last,
	input  logic [LENGTH_BITS-1:0] cfg_len,
	input  logic [15:0]            cfg_mix,
	ges_out_if.source              out_ch
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_INT  = 7'b0001000,
		ST_GAIN = 7'b0010000,
		ST_MIX  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [14:0] mem [TABLE_DEPTH];

	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       step_q;
	logic [7:0]             last_q;
	logic signed [15:0]     dry_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [14:0]            a_s1;
	logic [14:0]            b_s1;
	logic signed [32:0]     prod1_q;
	logic signed [31:0]     prod2_q;
	logic signed [34:0]     prod3_q;

	logic [LENGTH_BITS-1:0] div_rem_q;
	logic [LENGTH_BITS-1:0] div_den_q;
	logic [POS_W-1:0]       div_quo_q;
	logic [4:0]             div_cnt_q;

	logic                   out_valid_q;
	logic signed [15:0]     out_sample_q;
	logic                   out_clip_q;

	logic [7:0]             last8;
	logic [7:0]             idx;
	logic [7:0]             idx_b;
	logic                   mem_we;
	logic                   rd_en;
	logic [LENGTH_BITS:0]   rem_sh;
	logic [LENGTH_BITS:0]   rem_sub;
	logic                   rem_ge;
	logic signed [17:0]     gsum;
	logic [14:0]            gain15;
	logic signed [16:0]     wet;
	logic signed [17:0]     diff;
	logic [15:0]            mix_c;
	logic signed [20:0]     res;
	logic signed [15:0]     res_sat;
	logic                   res_clip;
	logic [POS_W:0]         pos_sum;
	logic                   out_load;

	assign last8 = (32'(cfg_last) > TABLE_DEPTH - 1) ? 8'(TABLE_DEPTH - 1) : cfg_last;
	assign idx   = (pos_q[POS_W-1:FRAC_W] > last_q) ? last_q : pos_q[POS_W-1:FRAC_W];
	assign idx_b = (idx < last_q) ? idx + 8'd1 : idx;

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign mem_we = q_pop && (q_item.mode == MODE_POINT)
		&& (32'(q_item.point_index) < TABLE_DEPTH);
	assign rd_en  = (state_q == ST_RD);

	always_ff @(posedge clk) begin
		if (mem_we) mem[AW'(q_item.point_index)] <= q_item.point_gain;
		if (rd_en) begin
			a_s1 <= mem[AW'(idx)];
			b_s1 <= mem[AW'(idx_b)];
		end
	end

	assign rem_sh  = {div_rem_q, div_quo_q[POS_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_den_q};
	assign rem_ge  = (rem_sh >= {1'b0, div_den_q});

	assign gsum   = {1'b0, a_s1} + {prod1_q[32], prod1_q[32:16]};
	assign gain15 = gsum[17] ? 15'd0 : ((gsum > 18'sd32767) ? 15'h7FFF : gsum[14:0]);

	assign wet   = prod2_q[31:15];
	assign diff  = {wet[16], wet} - {{2{dry_q[15]}}, dry_q};
	assign mix_c = (cfg_mix > MIX_FULL) ? MIX_FULL : cfg_mix;

	assign res = {{5{dry_q[15]}}, dry_q} + {prod3_q[34], prod3_q[34:15]};
	always_comb begin
		res_clip = 1'b1;
		if (res > 21'sd32767) res_sat = 16'sh7FFF;
		else if (res < -21'sd32768) res_sat = -16'sh8000;
		else begin
			res_sat  = res[15:0];
			res_clip = 1'b0;
		end
	end

	assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD:   frac_q <= pos_q[FRAC_W-1:0];
			ST_INT:  prod1_q <= ($signed({1'b0, b_s1}) - $signed({1'b0, a_s1}))
				* $signed({1'b0, frac_q});
			ST_GAIN: prod2_q <= dry_q * $signed({1'b0, gain15});
			ST_MIX:  prod3_q <= diff * $signed({1'b0, mix_c});
			default: ;
		endcase
		if (out_load) begin
			out_sample_q <= res_sat;
			out_clip_q   <= res_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			step_q      <= '0;
			last_q      <= LAST_RESET;
			dry_q       <= '0;
			div_rem_q   <= '0;
			div_den_q   <= '0;
			div_quo_q   <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.mode == MODE_SAMPLE) begin
						last_q <= last8;
						dry_q  <= q_item.sample_in;
						if (q_item.first_sample) begin
							pos_q <= '0;
							if (cfg_len > LENGTH_BITS'(1)) begin
								div_quo_q <= {last8, {FRAC_W{1'b0}}};
								div_rem_q <= '0;
								div_den_q <= cfg_len - LENGTH_BITS'(1);
								div_cnt_q <= '0;
								state_q   <= ST_DIV;
							end else begin
								step_q  <= '0;
								state_q <= ST_RD;
							end
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_DIV: begin
					div_rem_q <= rem_ge ? rem_sub[LENGTH_BITS-1:0] : rem_sh[LENGTH_BITS-1:0];
					div_quo_q <= {div_quo_q[POS_W-2:0], rem_ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(POS_W - 1)) begin
						step_q  <= {div_quo_q[POS_W-2:0], rem_ge};
						state_q <= ST_RD;
					end
				end
				ST_RD:   state_q <= ST_INT;
				ST_INT:  state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						pos_q   <= pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.clipped    = out_clip_q;

	`GES_ASSERT(a_state_onehot, $onehot(state_q))
	`GES_ASSERT_IMP(a_div_count, state_q == ST_DIV, div_cnt_q < 5'(POS_W))
	`GES_ASSERT_IMP(a_clip_extreme, out_valid_q && out_clip_q, out_sample_q == 16'sh7FFF || out_sample_q == -16'sh8000)
endmodule

// ===== design/gain_envelope_shaper.sv =====
// Gain envelope shaper: a point write enters the gain table when dequeued.
// A sample passes from dequeue through RD, INT, GAIN, MIX and OUT to the output
// register; a first sample with selection length above one adds step division.
// A two-entry request queue and an output register decouple both channels.
// Reset clears control state, position and step; the gain table is not cleared.
`timescale 1ns / 1ps
module gain_envelope_shaper
	import ges_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int LENGTH_BITS = 24,
	localparam int CfgW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ges_in_if.sink               in_ch,
	ges_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CfgW-1:0]      cfg_data
);
	logic [7:0]             last_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [15:0]            mix_q;
	logic                   q_valid;
	logic                   q_pop;
	item_t                  q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= LAST_RESET;
			len_q  <= LENGTH_BITS'(1);
			mix_q  <= MIX_FULL;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LAST_POINT: last_q <= cfg_data[7:0];
				REG_SEL_LEN:    len_q  <= cfg_data[LENGTH_BITS-1:0];
				REG_MIX:        mix_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ges_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	ges_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.cfg_last (last_q),
		.cfg_len  (len_q),
		.cfg_mix  (mix_q),
		.out_ch   (out_ch)
	);
endmodule

// ===== tb/sv/gain_envelope_shaper_tb.sv =====
// Testbench for gain_envelope_shaper: random gain tables, selections and mixes against a predictor
`timescale 1ns / 1ps
module gain_envelope_shaper_tb;
	import ges_pkg::*;

	localparam int DEPTH = 256;
	localparam int WAIT_LIMIT = 5000;
	localparam int SETTLE = 40;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               clipped;
	} shaped_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_LAST_POINT;
	logic [23:0] cfg_data = '0;

	ges_in_if in_ch ();
	ges_out_if out_ch ();

	gain_envelope_shaper dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state
	logic [14:0] gains [DEPTH];
	logic [23:0] pos, step;
	logic [7:0]  last_pt;
	logic [23:0] sel_len;
	logic [15:0] mix;

	item_t   pending_q [$];
	shaped_t shaped_q [$];
	int errors = 0, samples_seen = 0, points_seen = 0, clips_seen = 0;
	int tx_idle = 0, rx_idle = 0;
	int hold_reqs = 0, hold_done = 0, hold_left = 0;
	int quiet = 0;
	logic in_taken = 1'b0;

	initial forever #4 clk = ~clk;

	function automatic shaped_t shape_sample(item_t it);
		shaped_t r;
		longint a, b, g, dry, wet, res, np;
		int last, idx, m;
		last = last_pt;
		if (it.first_sample) begin
			pos = '0;
			if (sel_len > 1) step = ((longint'(last) << 16) / (longint'(sel_len) - 1)) & 24'hFFFFFF;
			else step = '0;
		end
		idx = pos >> 16;
		if (idx > last) idx = last;
		a = gains[idx];
		b = gains[idx < last ? idx + 1 : idx];
		g = a + (((b - a) * longint'(pos[15:0])) >>> 16);
		if (g < 0) g = 0;
		if (g > 32767) g = 32767;
		dry = it.sample_in;
		wet = (dry * g) >>> 15;
		m = mix > 32768 ? 32768 : mix;
		res = dry + (((wet - dry) * m) >>> 15);
		r.clipped = 1'b0;
		if (res > 32767) begin
			res = 32767;
			r.clipped = 1'b1;
		end
		if (res < -32768) begin
			res = -32768;
			r.clipped = 1'b1;
		end
		r.sample_out = res[15:0];
		np = longint'(pos) + step;
		pos = np > 24'hFFFFFF ? 24'hFFFFFF : np[23:0];
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
				item_t it;
				it = pending_q.pop_front();
				in_ch.mode <= it.mode;
				in_ch.point_index <= it.point_index;
				in_ch.point_gain <= it.point_gain;
				in_ch.sample_in <= it.sample_in;
				in_ch.first_sample <= it.first_sample;
				in_ch.valid <= 1'b1;
			end else
				in_ch.valid <= 1'b0;
		end
	end

	// result receiver with occasional long hold-off
	always @(negedge clk) begin
		if (hold_left == 0 && hold_reqs != hold_done) begin
			hold_done = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle);
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		in_taken <= in_ch.valid && in_ch.ready;
		if (in_ch.valid && in_ch.ready) begin
			item_t it;
			it = '{in_ch.mode, in_ch.point_index, in_ch.point_gain, in_ch.sample_in,
				in_ch.first_sample};
			if (it.mode == MODE_POINT) begin
				gains[it.point_index] = it.point_gain;
				points_seen++;
			end else
				shaped_q.push_back(shape_sample(it));
		end
		if (out_ch.valid && out_ch.ready) begin
			shaped_t w;
			samples_seen++;
			if (out_ch.clipped) clips_seen++;
			if (shaped_q.size() == 0)
				report("unexpected result", out_ch.sample_out, 0);
			else begin
				w = shaped_q.pop_front();
				if (out_ch.sample_out !== w.sample_out)
					report("sample_out", out_ch.sample_out, w.sample_out);
				if (out_ch.clipped !== w.clipped)
					report("clipped", out_ch.clipped, w.clipped);
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == WAIT_LIMIT) begin
			$display("[gain_envelope_shaper] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LAST_POINT: last_pt = val[7:0];
			REG_SEL_LEN:    sel_len = val;
			REG_MIX:        mix = val[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_ch.valid || shaped_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_point(int idx, int g);
		item_t it;
		it = '0;
		it.mode = MODE_POINT;
		it.point_index = idx;
		it.point_gain = g;
		it.sample_in = $urandom;
		pending_q.push_back(it);
	endtask

	task automatic add_sample(logic signed [15:0] s, logic first);
		item_t it;
		it = '0;
		it.mode = MODE_SAMPLE;
		it.sample_in = s;
		it.first_sample = first;
		it.point_index = $urandom;
		it.point_gain = $urandom;
		pending_q.push_back(it);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int cfgs [12][3] = '{
			'{255, 1, 32768}, '{0, 5, 32768}, '{1, 2, 40000}, '{255, 16777215, 0},
			'{16, 20, 16384}, '{255, 2, 65535}, '{7, 0, 20000}, '{200, 300, 32768},
			'{3, 10, 12345}, '{255, 64, 32768}, '{128, 33, 30000}, '{50, 7, 32768}
		};
		int n, k, len;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_POINT;
		in_ch.point_index = '0;
		in_ch.point_gain = '0;
		in_ch.sample_in = '0;
		in_ch.first_sample = 1'b0;
		out_ch.ready = 1'b0;
		pos = '0;
		step = '0;
		last_pt = LAST_RESET;
		sel_len = 24'd1;
		mix = MIX_FULL;
		foreach (gains[i]) gains[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// load the whole table so no sample reads an unwritten entry
		for (int i = 0; i < DEPTH; i++)
			add_point(i, i % 3 == 0 ? 32767 : (i % 3 == 1 ? 0 : $urandom_range(32767)));
		drain();

		// directed: extreme points and samples, table ends
		write_reg(REG_SEL_LEN, 24'd4);
		add_point(0, 32767);
		add_point(255, 0);
		add_point(1, 0);
		add_point(254, 32767);
		add_sample(16'sh8000, 1'b1);
		add_sample(16'sh7FFF, 1'b0);
		add_sample(16'sh0000, 1'b0);
		add_sample(-16'sd1, 1'b0);
		add_sample(16'sh8000, 1'b0);
		add_sample(16'sh7FFF, 1'b0);
		add_sample(16'sh7FFF, 1'b1);
		add_sample(16'sh8000, 1'b0);
		drain();
		write_reg(REG_MIX, 16'd0);
		add_sample(16'sh8000, 1'b1);
		add_sample(16'sh7FFF, 1'b0);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				tx_idle = 10;
				rx_idle = 46;
			end else if (p < 8) begin
				tx_idle = 46;
				rx_idle = 10;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			write_reg(REG_LAST_POINT, cfgs[p][0]);
			write_reg(REG_SEL_LEN, cfgs[p][1]);
			write_reg(REG_MIX, cfgs[p][2]);
			n = 0;
			while (n < 135) begin
				len = cfgs[p][1];
				k = (len > 60 || len < 1) ? $urandom_range(60, 1) : len + $urandom_range(4);
				if ($urandom_range(9) == 0) k = $urandom_range(3, 1);
				add_sample(rand_sample(), 1'b1);
				for (int j = 1; j < k; j++) begin
					if ($urandom_range(19) == 0)
						add_point($urandom_range(255), $urandom_range(32767));
					add_sample(rand_sample(), $urandom_range(39) == 0);
				end
				n += k;
			end
			if (p == 2 || p == 9) hold_reqs++;
			drain();
		end

		$display("shaped %0d samples and wrote %0d table points over 12 register settings",
			samples_seen, points_seen);
		$display("%0d results were flagged as clipped, %0d mismatches", clips_seen, errors);
		if (errors == 0)
			$display("[gain_envelope_shaper] OK");
		else
			$display("[gain_envelope_shaper] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/ges_pkg.sv
design/ges_in_if.sv
design/ges_out_if.sv
design/ges_front.sv
design/ges_back.sv
design/gain_envelope_shaper.sv
tb/sv/gain_envelope_shaper_tb.sv
